@@ rtl/core/esd_pkg.sv @@
`timescale 1ns / 1ps

package esd_pkg;

    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X_LO   = 8'h78;
    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [1:0] OCT_MAX   = 2'd3;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [3:0] {
        MODE_PLAIN = 4'b0001,
        MODE_ESC   = 4'b0010,
        MODE_HEX   = 4'b0100,
        MODE_OCT   = 4'b1000
    } t_mode;

    // decoded bytes of one input item, at most three
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] cnt;
        logic       last;
    } t_group;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

    // {is digit, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        logic       ok;
        d  = 8'h00;
        ok = 1'b1;
        case (c) inside
            [8'h30:8'h39]: d = c - 8'h30;
            [8'h61:8'h66]: d = c - 8'h57;
            [8'h41:8'h46]: d = c - 8'h37;
            default:       ok = 1'b0;
        endcase
        return {ok, d[3:0]};
    endfunction

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h37);
    endfunction

    // {is simple escape, mapped byte}
    function automatic logic [8:0] simple_map(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h61:   r = {1'b1, 8'd7};
            8'h62:   r = {1'b1, 8'd8};
            8'h66:   r = {1'b1, 8'd12};
            8'h6E:   r = {1'b1, 8'd10};
            8'h72:   r = {1'b1, 8'd13};
            8'h74:   r = {1'b1, 8'd9};
            8'h76:   r = {1'b1, 8'd11};
            8'h5C, 8'h27, 8'h22, 8'h3F: r = {1'b1, c};
            default: r = {1'b0, c};
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/esd_in_if.sv @@
`timescale 1ns / 1ps

interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

@@ rtl/core/esd_out_if.sv @@
`timescale 1ns / 1ps

interface esd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

@@ rtl/core/esd_front.sv @@
`timescale 1ns / 1ps

module esd_front
    import esd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    esd_in_if.sink    i_in,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_group    o_group
);

    t_mode      r_mode, n_mode;
    logic [7:0] r_acc, n_acc;
    logic [1:0] r_cnt, n_cnt;
    logic       r_upper, n_upper;

    logic [7:0] v_b [4];
    logic [1:0] v_n;
    logic       v_plain;
    logic [4:0] v_hex;
    logic [8:0] v_simple;
    logic [7:0] v_ch;
    logic       v_last;
    logic       accept;

    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;
    assign v_ch       = i_in.in_byte;
    assign v_last     = i_in.in_last;

    always_comb begin
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_upper  = r_upper;
        v_b[0]   = 8'h00;
        v_b[1]   = 8'h00;
        v_b[2]   = 8'h00;
        v_b[3]   = 8'h00;
        v_n      = 2'd0;
        v_plain  = 1'b0;
        v_hex    = hex_value(v_ch);
        v_simple = simple_map(v_ch);
        case (r_mode)
            MODE_PLAIN: v_plain = 1'b1;
            MODE_ESC: begin
                if (v_simple[8]) begin
                    v_b[v_n] = v_simple[7:0];
                    v_n      = v_n + 2'd1;
                    n_mode   = MODE_PLAIN;
                end else if (v_ch == CH_X_LO || v_ch == CH_X_UP) begin
                    n_mode  = MODE_HEX;
                    n_acc   = 8'h00;
                    n_cnt   = 2'd0;
                    n_upper = (v_ch == CH_X_UP);
                    if (v_last) begin
                        v_b[v_n] = BACKSLASH;
                        v_n      = v_n + 2'd1;
                        v_b[v_n] = v_ch;
                        v_n      = v_n + 2'd1;
                    end
                end else if (is_oct(v_ch)) begin
                    n_mode = MODE_OCT;
                    n_acc  = {5'd0, v_ch[2:0]};
                    n_cnt  = 2'd1;
                    if (v_last) begin
                        v_b[v_n] = n_acc;
                        v_n      = v_n + 2'd1;
                    end
                end else begin
                    v_b[v_n] = BACKSLASH;
                    v_n      = v_n + 2'd1;
                    v_b[v_n] = v_ch;
                    v_n      = v_n + 2'd1;
                    n_mode   = MODE_PLAIN;
                end
            end
            MODE_HEX: begin
                if (v_hex[4]) begin
                    n_acc = {r_acc[3:0], v_hex[3:0]};
                    n_cnt = 2'd1;
                    if (v_last) begin
                        v_b[v_n] = n_acc;
                        v_n      = v_n + 2'd1;
                    end
                end else begin
                    // no digits: the letter is given back as written
                    if (r_cnt == 2'd0) begin
                        v_b[v_n] = BACKSLASH;
                        v_n      = v_n + 2'd1;
                        v_b[v_n] = r_upper ? CH_X_UP : CH_X_LO;
                        v_n      = v_n + 2'd1;
                    end else begin
                        v_b[v_n] = r_acc;
                        v_n      = v_n + 2'd1;
                    end
                    n_mode  = MODE_PLAIN;
                    v_plain = 1'b1;
                end
            end
            MODE_OCT: begin
                if (is_oct(v_ch)) begin
                    n_acc = {r_acc[4:0], v_ch[2:0]};
                    n_cnt = r_cnt + 2'd1;
                    if (n_cnt == OCT_MAX || n_cnt == 2'd0) begin
                        v_b[v_n] = n_acc;
                        v_n      = v_n + 2'd1;
                        n_mode   = MODE_PLAIN;
                    end else if (v_last) begin
                        v_b[v_n] = n_acc;
                        v_n      = v_n + 2'd1;
                    end
                end else begin
                    v_b[v_n] = r_acc;
                    v_n      = v_n + 2'd1;
                    n_mode   = MODE_PLAIN;
                    v_plain  = 1'b1;
                end
            end
            default: v_plain = 1'b1;
        endcase
        // ending character goes through the plain path
        if (v_plain) begin
            if (v_ch == BACKSLASH && !v_last) begin
                n_mode = MODE_ESC;
            end else begin
                v_b[v_n] = v_ch;
                v_n      = v_n + 2'd1;
            end
        end
        if (v_last) begin
            n_mode  = MODE_PLAIN;
            n_acc   = 8'h00;
            n_cnt   = 2'd0;
            n_upper = 1'b0;
        end
    end

    assign o_group = '{b0: v_b[0], b1: v_b[1], b2: v_b[2], cnt: v_n, last: v_last};
    assign o_push  = accept && (v_n != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PLAIN;
            r_acc   <= 8'h00;
            r_cnt   <= 2'd0;
            r_upper <= 1'b0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_upper <= n_upper;
        end
    end

    a_last_gives_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.in_last) |-> o_push)
        else $error("final item produced no bytes");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.in_last) |=> (r_mode == MODE_PLAIN && r_cnt == 2'd0))
        else $error("state not cleared after final item");

endmodule

@@ rtl/core/esd_queue.sv @@
`timescale 1ns / 1ps

module esd_queue
    import esd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_group    i_group,
    input  logic      i_pop,
    output t_group    o_head,
    output t_q_status o_status
);

    localparam logic [Q_AW:0] FULL_CNT = (Q_AW + 1)'(Q_DEPTH);
    localparam logic [Q_AW-1:0] LAST_PTR = Q_AW'(Q_DEPTH - 1);

    t_group          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    assign o_head          = r_mem[r_rp];
    assign o_status.valid  = (r_cnt != '0);
    assign o_status.full   = (r_cnt == FULL_CNT);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ptr_inc(r_wp);
            if (i_pop)  r_rp <= ptr_inc(r_rp);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_status.valid)
        else $error("pop from empty queue");

endmodule

@@ rtl/core/esd_back.sv @@
`timescale 1ns / 1ps

module esd_back
    import esd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_group    i_head,
    input  t_q_status i_q_status,
    output logic      o_pop,
    esd_out_if.source o_out
);

    logic [1:0] r_idx;
    logic       r_ov;
    logic [7:0] r_ob;
    logic       r_ol;
    logic       advance;
    logic       end_of_group;
    logic [7:0] sel_byte;

    assign advance      = !r_ov || o_out.ready;
    assign end_of_group = (r_idx == i_head.cnt - 2'd1);
    assign o_pop        = advance && i_q_status.valid && end_of_group;

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_head.b0;
            2'd1:    sel_byte = i_head.b1;
            default: sel_byte = i_head.b2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_q_status.valid) begin
            r_ob <= sel_byte;
            r_ol <= i_head.last && end_of_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_idx <= 2'd0;
        end else if (advance) begin
            r_ov <= i_q_status.valid;
            if (i_q_status.valid) begin
                r_idx <= end_of_group ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_ob;
    assign o_out.out_last = r_ol;

    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_status.valid |-> (r_idx < i_head.cnt))
        else $error("byte index beyond group");

    a_idx_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_status.valid |-> (r_idx == 2'd0))
        else $error("byte index left open with empty queue");

endmodule

@@ rtl/core/c_escape_sequence_decoder.sv @@
`timescale 1ns / 1ps

// C escape sequence decoder: turns the characters of a C string body into
// the raw bytes that its escapes stand for.
// i_in carries one character per item (in_byte, in_last on the final one);
// o_out carries decoded bytes, out_last on the final byte of the string.
// Both channels move an item when valid and ready are high at a clock edge.
// The front decodes one character per cycle, while the queue has room, into
// a group of zero to three bytes and pushes it into a two-entry queue; the
// back sends one byte per cycle from the queue head through an output register
// while o_out.ready is high. An item's first byte enters the queue at the edge
// that accepts it and leaves through the output register. Input runs at one
// character per cycle while each gives at most one byte and o_out.ready is
// high; a group of two or three bytes goes out byte by byte, and input stalls
// once both queue entries are taken. i_in.ready depends on the queue fill
// only, never on o_out.ready. When the receiver stalls, the output byte holds
// and the queue fills, then input stops. Synchronous active-low reset returns
// the decoder to plain mode, empties the queue and drops o_out.valid.
module c_escape_sequence_decoder
    import esd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    esd_in_if.sink    i_in,
    esd_out_if.source o_out
);

    logic      push;
    logic      pop;
    t_group    group;
    t_group    head;
    t_q_status q_status;

    esd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_group    (group)
    );

    esd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_group  (group),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    esd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

@@ sim/esd_checker.sv @@
`timescale 1ns / 1ps

module esd_checker
    import esd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    esd_in_if    i_in_mon,
    esd_out_if   i_out_mon,
    output int   o_pending,
    output int   o_fail_count
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_raw_byte;

    // decoder state as the bytes so far imply it
    t_mode      mode;
    logic [7:0] acc;
    logic [1:0] digit_cnt;
    logic       x_upper;

    logic [7:0] step_bytes[$];
    t_raw_byte  raw_bytes_due[$];

    // -1 when c is not a hex digit
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic logic octal_digit(input logic [7:0] c);
        return c >= "0" && c <= "7";
    endfunction

    // {is simple escape, raw byte}
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        case (c)
            "a": return {1'b1, 8'd7};
            "b": return {1'b1, 8'd8};
            "f": return {1'b1, 8'd12};
            "n": return {1'b1, 8'd10};
            "r": return {1'b1, 8'd13};
            "t": return {1'b1, 8'd9};
            "v": return {1'b1, 8'd11};
            BACKSLASH, "'", "\"", "?": return {1'b1, c};
            default: return {1'b0, 8'h00};
        endcase
    endfunction

    task automatic clear_decoder();
        mode      = MODE_PLAIN;
        acc       = 8'h00;
        digit_cnt = 2'd0;
        x_upper   = 1'b0;
    endtask

    task automatic take_plain(input logic [7:0] c, input logic last);
        if (c == BACKSLASH && !last) begin
            mode = MODE_ESC;
        end else begin
            step_bytes.push_back(c);
        end
    endtask

    task automatic take_escape(input logic [7:0] c, input logic last);
        logic [8:0] s;
        s = simple_escape(c);
        if (s[8]) begin
            step_bytes.push_back(s[7:0]);
            mode = MODE_PLAIN;
        end else if (c == CH_X_LO || c == CH_X_UP) begin
            mode      = MODE_HEX;
            acc       = 8'h00;
            digit_cnt = 2'd0;
            x_upper   = (c == CH_X_UP);
            if (last) begin
                step_bytes.push_back(BACKSLASH);
                step_bytes.push_back(c);
            end
        end else if (octal_digit(c)) begin
            mode      = MODE_OCT;
            acc       = {5'd0, c[2:0]};
            digit_cnt = 2'd1;
            if (last) step_bytes.push_back(acc);
        end else begin
            step_bytes.push_back(BACKSLASH);
            step_bytes.push_back(c);
            mode = MODE_PLAIN;
        end
    endtask

    task automatic take_hex(input logic [7:0] c, input logic last);
        int v;
        v = hex_nibble(c);
        if (v >= 0) begin
            acc       = {acc[3:0], v[3:0]};
            digit_cnt = 2'd1;
            if (last) step_bytes.push_back(acc);
        end else begin
            // no digits: the escape is passed on as written
            if (digit_cnt == 2'd0) begin
                step_bytes.push_back(BACKSLASH);
                step_bytes.push_back(x_upper ? CH_X_UP : CH_X_LO);
            end else begin
                step_bytes.push_back(acc);
            end
            mode = MODE_PLAIN;
            take_plain(c, last);
        end
    endtask

    task automatic take_octal(input logic [7:0] c, input logic last);
        if (octal_digit(c)) begin
            acc       = {acc[4:0], c[2:0]};
            digit_cnt = digit_cnt + 2'd1;
            if (digit_cnt == OCT_MAX || digit_cnt == 2'd0) begin
                step_bytes.push_back(acc);
                mode = MODE_PLAIN;
            end else if (last) begin
                step_bytes.push_back(acc);
            end
        end else begin
            step_bytes.push_back(acc);
            mode = MODE_PLAIN;
            take_plain(c, last);
        end
    endtask

    task automatic decode_char(input logic [7:0] c, input logic last);
        step_bytes.delete();
        case (mode)
            MODE_PLAIN: take_plain(c, last);
            MODE_ESC:   take_escape(c, last);
            MODE_HEX:   take_hex(c, last);
            default:    take_octal(c, last);
        endcase
        foreach (step_bytes[i]) begin
            raw_bytes_due.push_back('{data: step_bytes[i],
                                      last: last && (i == step_bytes.size() - 1)});
        end
        if (last) clear_decoder();
    endtask

    task automatic report_mismatch(input string msg);
        if (o_fail_count < 40) $display("[%0t] esd_checker: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_byte(input logic [7:0] data, input logic last);
        t_raw_byte want;
        if (raw_bytes_due.size() == 0) begin
            report_mismatch($sformatf("byte %02h last %0b with none due", data, last));
            return;
        end
        want = raw_bytes_due.pop_front();
        if (data !== want.data) begin
            report_mismatch($sformatf("out_byte %02h, want %02h", data, want.data));
        end
        if (last !== want.last) begin
            report_mismatch($sformatf("out_last %0b on byte %02h, want %0b",
                                      last, data, want.last));
        end
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_decoder();
            raw_bytes_due.delete();
            o_pending <= 0;
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                decode_char(i_in_mon.in_byte, i_in_mon.in_last);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                check_byte(i_out_mon.out_byte, i_out_mon.out_last);
            end
            o_pending <= raw_bytes_due.size();
        end
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import esd_pkg::*;

    localparam int DIRECTED_CHARS = 25;
    localparam int RANDOM_CHARS   = 245;
    localparam int STALL_LIMIT    = 3000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_WAIT     = 20;

    logic i_clk;
    logic i_rst_n;
    int   pending;
    int   fail_count;
    int   idle_cycles;
    int   sent_count;
    int   burst_left;
    bit   calm;
    bit   hold_req;

    logic [7:0] text[$];
    string      esc_letters = "abfnrtv\\'\"?";
    string      hex_digits  = "0123456789abcdefABCDEF";

    esd_in_if  in_ch ();
    esd_out_if out_ch ();

    c_escape_sequence_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    esd_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial i_clk = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ends the run when nothing moves on either channel for too long
    initial idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : receiver
        int r;
        int n;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    out_ch.ready <= 1'b1;
                    n = $urandom_range(30, 80);
                end else if (r < 65) begin
                    out_ch.ready <= 1'b1;
                    n = 1;
                end else if (r < 95) begin
                    out_ch.ready <= 1'b0;
                    n = $urandom_range(1, 3);
                end else begin
                    out_ch.ready <= 1'b0;
                    n = $urandom_range(10, 40);
                end
                repeat (n) begin
                    @(posedge i_clk);
                    if (hold_req) break;
                end
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (burst_left > 0 || calm || r < 55) gap = 0;
        else if (r < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 40);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= c;
        in_ch.in_last <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (burst_left > 0) burst_left--;
        sent_count++;
    endtask

    task automatic send_text();
        foreach (text[i]) send_char(text[i], i == text.size() - 1);
    endtask

    task automatic load_text(input string s);
        text.delete();
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    endtask

    // a string of plain characters and whole escapes with random content, now and then cut short
    task automatic build_random_text();
        int target;
        int kind;
        int n;
        text.delete();
        target = $urandom_range(1, 12);
        while (text.size() < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                text.push_back(8'($urandom_range(1, 255)));
            end else if (kind < 50) begin
                text.push_back(BACKSLASH);
                text.push_back(esc_letters[$urandom_range(0, 10)]);
            end else if (kind < 70) begin
                text.push_back(BACKSLASH);
                text.push_back($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
                n = $urandom_range(0, 4);
                repeat (n) text.push_back(hex_digits[$urandom_range(0, 21)]);
            end else if (kind < 88) begin
                text.push_back(BACKSLASH);
                n = $urandom_range(1, 4);
                repeat (n) text.push_back(8'("0" + $urandom_range(0, 7)));
            end else begin
                text.push_back(BACKSLASH);
                text.push_back(8'($urandom_range(1, 255)));
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            while (text.size() > target) void'(text.pop_back());
        end
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h01;
        in_ch.in_last = 1'b0;
        sent_count    = 0;
        burst_left    = 0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        text.delete();
        text.push_back(8'h01);
        text.push_back(8'hFF);
        send_text();
        // long hex value keeps the low byte, then a plain character ends it
        load_text("\\xFf1g");
        send_text();
        // hex with no digits ended by a new escape
        load_text("\\X\\n");
        send_text();
        // three octal digits close the escape, the fourth is plain
        load_text("\\7775");
        send_text();
        load_text("\\q");
        send_text();
        // octal ended by a backslash that is the final character
        load_text("\\12\\");
        send_text();
        load_text("\\x");
        send_text();

        // the receiver holds off while the sender keeps offering items
        hold_req   = 1'b1;
        burst_left = 40;
        while (sent_count < DIRECTED_CHARS + RANDOM_CHARS) begin
            calm = ($urandom_range(0, 3) == 0);
            build_random_text();
            send_text();
        end
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/esd_pkg.sv
rtl/core/esd_in_if.sv
rtl/core/esd_out_if.sv
rtl/core/esd_front.sv
rtl/core/esd_queue.sv
rtl/core/esd_back.sv
rtl/core/c_escape_sequence_decoder.sv
sim/esd_checker.sv
sim/tb_top.sv
